/* hw/rtl/fprd_pkg.sv */
// Shared types and constants for the framed packet receiver and decoder.
// Used by fprd_parser, fprd_decode and the top level. No dependencies.
`default_nettype none
package fprd_pkg;

  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 5;
  localparam int DECODE_BYTES = 8;
  localparam int IDX_W        = 3;
  localparam int VAL_W        = 16;
  localparam int REG_IDX_W    = 3;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;

  localparam logic [1:0] KIND_COLOR  = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_COLOR_HDR   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_TAIL  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CIRCLE_HDR  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CIRCLE_TAIL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LINE_HDR    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LINE_TAIL   = 3'd5;

  typedef logic [DECODE_BYTES-1:0][BYTE_W-1:0] store_t;

  typedef struct packed {
    logic [BYTE_W-1:0] color_hdr;
    logic [BYTE_W-1:0] color_tail;
    logic [BYTE_W-1:0] circle_hdr;
    logic [BYTE_W-1:0] circle_tail;
    logic [BYTE_W-1:0] line_hdr;
    logic [BYTE_W-1:0] line_tail;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic [1:0]       kind;
    logic [CNT_W-1:0] length;
    logic             overflow;
  } pkt_status_t;

endpackage
`default_nettype wire

/* hw/rtl/framed_packet_receiver_decoder_core.sv */
// A result appears on m_tvalid in the cycle after its tail byte is accepted.
// Throughput: one received byte per cycle; the single output register lets the
// next byte enter while a finished result waits, as long as m_tready drains it.
// Reset (rst, synchronous): clears header/tail registers, parser state, payload
// store and m_tvalid. Depends on fprd_pkg, fprd_parser and fprd_decode.
`default_nettype none
module framed_packet_receiver_decoder_core #(
  parameter int MAX_PAYLOAD = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // received byte stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  // decoded packet stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // [1:0] packet_kind, [6:2] payload_length,
                                      // [7] overflow_seen, [15:8] first_payload_byte,
                                      // [31:16] value_x, [47:32] value_y
);
  import fprd_pkg::*;

  cfg_t                    cfg;
  pkt_status_t             status;
  store_t                  store;
  logic                    accept;
  logic signed [VAL_W-1:0] value_x, value_y;

  // Header and tail registers; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLOR_HDR:   cfg.color_hdr   <= cfg_data;
        REG_COLOR_TAIL:  cfg.color_tail  <= cfg_data;
        REG_CIRCLE_HDR:  cfg.circle_hdr  <= cfg_data;
        REG_CIRCLE_TAIL: cfg.circle_tail <= cfg_data;
        REG_LINE_HDR:    cfg.line_hdr    <= cfg_data;
        REG_LINE_TAIL:   cfg.line_tail   <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Take a new byte whenever the output register is empty or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  fprd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .rx_byte (s_tdata),
    .status  (status),
    .store   (store)
  );

  // The decode reads the store as it stands before the tail byte's edge,
  // which holds up to the first eight payload bytes of the packet being closed.
  fprd_decode u_decode (
    .kind    (status.kind),
    .store   (store),
    .value_x (value_x),
    .value_y (value_y)
  );

  // Output register: load on a tail byte, hold while stalled, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (status.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      m_tdata <= {value_y, value_x, store[0], status.overflow, status.length, status.kind};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fprd_decode.sv */
// Signed decode of the stored ASCII payload into circle X/Y or line angle.
// Depends on fprd_pkg.
`default_nettype none
module fprd_decode (
  input  wire logic [1:0]                  kind,
  input  wire fprd_pkg::store_t            store,
  output logic signed [fprd_pkg::VAL_W-1:0] value_x,
  output logic signed [fprd_pkg::VAL_W-1:0] value_y
);
  import fprd_pkg::*;

  logic signed [VAL_W-1:0] d [DECODE_BYTES];
  logic signed [VAL_W-1:0] cx_mag, cy_mag, ln_mag;

  always_comb begin
    for (int i = 0; i < DECODE_BYTES; i++) begin
      d[i] = signed'({{(VAL_W-BYTE_W){1'b0}}, store[i]}) - VAL_W'(signed'(ASCII_ZERO));
    end
    cx_mag = 16'sd100 * d[1] + 16'sd10 * d[2] + d[3];
    cy_mag = 16'sd100 * d[5] + 16'sd10 * d[6] + d[7];
    ln_mag = 16'sd10 * d[1] + d[2];
  end

  always_comb begin
    value_x = '0;
    value_y = '0;
    case (kind)
      KIND_COLOR: begin
        value_x = '0;
        value_y = '0;
      end
      KIND_CIRCLE: begin
        value_x = (store[0] == ASCII_ZERO) ? cx_mag : -cx_mag;
        value_y = (store[4] == ASCII_ZERO) ? cy_mag : -cy_mag;
      end
      default: begin
        // line, and the unused kind code treated as line
        value_x = (store[0] == ASCII_ZERO) ? -ln_mag : ln_mag;
        value_y = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/fprd_parser.sv */
// Header hunt, payload capture and tail detection for one accepted byte per cycle.
// Depends on fprd_pkg.
`default_nettype none
module fprd_parser #(
  parameter int MAX_PAYLOAD = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fprd_pkg::cfg_t              cfg,
  input  wire logic                        accept,
  input  wire logic [fprd_pkg::BYTE_W-1:0] rx_byte,
  output fprd_pkg::pkt_status_t            status,
  output fprd_pkg::store_t                 store
);
  import fprd_pkg::*;

  logic             receiving;
  logic [1:0]       active_kind;
  logic [CNT_W-1:0] byte_count;
  logic             overflow_flag;

  logic [BYTE_W-1:0] tail_byte;
  logic              is_tail;

  always_comb begin
    case (active_kind)
      KIND_COLOR:  tail_byte = cfg.color_tail;
      KIND_CIRCLE: tail_byte = cfg.circle_tail;
      default:     tail_byte = cfg.line_tail;
    endcase
    is_tail = receiving && (rx_byte == tail_byte);
  end

  always_comb begin
    status.done     = accept && is_tail;
    status.kind     = (active_kind == KIND_COLOR || active_kind == KIND_CIRCLE) ?
                      active_kind : KIND_LINE;
    status.length   = byte_count;
    status.overflow = overflow_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving     <= 1'b0;
      active_kind   <= KIND_COLOR;
      byte_count    <= '0;
      overflow_flag <= 1'b0;
      store         <= '0;
    end else if (accept) begin
      if (!receiving) begin
        // first matching header wins: colour, circle, line
        if (rx_byte == cfg.color_hdr || rx_byte == cfg.circle_hdr ||
            rx_byte == cfg.line_hdr) begin
          receiving     <= 1'b1;
          byte_count    <= '0;
          overflow_flag <= 1'b0;
          if (rx_byte == cfg.color_hdr) begin
            active_kind <= KIND_COLOR;
          end else if (rx_byte == cfg.circle_hdr) begin
            active_kind <= KIND_CIRCLE;
          end else begin
            active_kind <= KIND_LINE;
          end
        end
      end else if (is_tail) begin
        receiving  <= 1'b0;
        byte_count <= '0;
      end else begin
        if (byte_count < CNT_W'(DECODE_BYTES)) begin
          store[byte_count[IDX_W-1:0]] <= rx_byte;
        end
        // saturate the count and flag the excess
        if (byte_count < CNT_W'(MAX_PAYLOAD)) begin
          byte_count <= byte_count + 1'b1;
        end else begin
          overflow_flag <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
